// ----- src/diffuse_specular_shading_macros.svh -----
`ifndef DIFFUSE_SPECULAR_SHADING_MACROS_SVH
`define DIFFUSE_SPECULAR_SHADING_MACROS_SVH

// Both macros expect clk and arst_n in the scope where they are used.
`define DSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- src/dss_pkg.sv -----
`timescale 1ns / 1ps
package dss_pkg;
	localparam int COLOR_FRAC_BITS_DEF = 15;
	localparam int LDIR_W = 24;
	localparam int NORM_W = 16;
	localparam int LANE_W = 16;
	localparam int RGB_W = 48;
	localparam int COLOR_W = 16;
	localparam int MUL_W = 32;
	localparam int L2_W = 48;
	localparam int N2_W = 32;
	localparam int DT_W = 42;
	localparam int LEN_L_W = 24;
	localparam int LEN_N_W = 17;
	localparam int DEN_W = 42;
	localparam int X_W = 64;
	localparam int Q_W = 48;
	localparam int R_W = 70;
	localparam int ACC_W = 32;
	localparam int SQRT_STEPS = 24;

	typedef enum logic [1:0] {
		IT_SQRT = 2'b01,
		IT_DIV  = 2'b10
	} iter_mode_t;

	typedef struct packed {
		logic       start;
		iter_mode_t mode;
	} iter_req_t;
endpackage

// ----- src/dss_if.sv -----
`timescale 1ns / 1ps
interface dss_in_if;
	import dss_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     first_light;
	logic signed [LDIR_W-1:0] light_dir_x;
	logic signed [LDIR_W-1:0] light_dir_y;
	logic signed [LDIR_W-1:0] light_dir_z;
	logic signed [NORM_W-1:0] normal_x;
	logic signed [NORM_W-1:0] normal_y;
	logic signed [NORM_W-1:0] normal_z;
	logic [RGB_W-1:0]         diffuse_rgb;
	logic [RGB_W-1:0]         intensity_rgb;

	modport source (output valid, first_light, light_dir_x, light_dir_y, light_dir_z,
		normal_x, normal_y, normal_z, diffuse_rgb, intensity_rgb, input ready);
	modport sink (input valid, first_light, light_dir_x, light_dir_y, light_dir_z,
		normal_x, normal_y, normal_z, diffuse_rgb, intensity_rgb, output ready);
endinterface

interface dss_out_if;
	import dss_pkg::*;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] color_red;
	logic [COLOR_W-1:0] color_green;
	logic [COLOR_W-1:0] color_blue;
	logic [COLOR_W-1:0] diffuse_factor;

	modport source (output valid, color_red, color_green, color_blue, diffuse_factor,
		input ready);
	modport sink (input valid, color_red, color_green, color_blue, diffuse_factor,
		output ready);
endinterface

// ----- src/dss_mul.sv -----
`timescale 1ns / 1ps
module dss_mul import dss_pkg::*; (
	input  logic               clk,
	input  logic [MUL_W-1:0]   a,
	input  logic [MUL_W-1:0]   b,
	output logic [2*MUL_W-1:0] p
);
	logic [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
	end

	assign p = p_q;
endmodule

// ----- src/dss_iter.sv -----
`timescale 1ns / 1ps
module dss_iter import dss_pkg::*; #(
	parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  iter_req_t        req,
	input  logic [X_W-1:0]   opnd_a,
	input  logic [DEN_W-1:0] opnd_b,
	output logic             busy,
	output logic [Q_W-1:0]   result
);
	localparam int DIV_STEPS = COLOR_FRAC_BITS + 4;
	localparam int MAX_STEPS = DIV_STEPS > SQRT_STEPS ? DIV_STEPS : SQRT_STEPS;
	localparam int CNT_W = $clog2(MAX_STEPS + 1);

	logic             busy_q;
	iter_mode_t       mode_q;
	logic [CNT_W-1:0] cnt_q;
	logic [R_W-1:0]   a_q;
	logic [R_W-1:0]   b_q;
	logic [Q_W-1:0]   q_q;
	logic [R_W-1:0]   sub;
	logic             ge;

	always_comb begin
		unique case (mode_q)
			IT_SQRT: sub = R_W'(q_q) + b_q;
			default: sub = b_q;
		endcase
		ge = a_q >= sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= IT_SQRT;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			mode_q <= req.mode;
			cnt_q  <= (req.mode == IT_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= R_W'(opnd_a);
			q_q <= '0;
			if (req.mode == IT_SQRT) begin
				b_q <= R_W'(1) << (2 * SQRT_STEPS - 2);
			end else begin
				b_q <= R_W'(opnd_b) << (DIV_STEPS - 1);
			end
		end else if (busy_q) begin
			if (ge) begin
				a_q <= a_q - sub;
			end
			unique case (mode_q)
				IT_SQRT: begin
					q_q <= ge ? (q_q >> 1) + b_q[Q_W-1:0] : q_q >> 1;
					b_q <= b_q >> 2;
				end
				default: begin
					q_q <= {q_q[Q_W-2:0], ge};
					b_q <= b_q >> 1;
				end
			endcase
		end
	end

	assign busy   = busy_q;
	assign result = q_q;
endmodule

// ----- src/diffuse_specular_shading.sv -----
`timescale 1ns / 1ps
// Each light word needs 27 products on the shared 32 by 32 multiplier, two 24-step square roots
// and two (COLOR_FRAC_BITS+4)-step divisions on the shared unit, each of which may be skipped.
// A new word is taken only after the previous word's result is in the output register, later while a result waits.
// Reset clears the colour accumulator, the sequencer and the output valid.
module diffuse_specular_shading import dss_pkg::*; #(
	parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dss_in_if.sink    light,
	dss_out_if.source shade
);
	localparam int F = COLOR_FRAC_BITS;
	localparam int DW = F + 4;
	localparam int CW = F + 1;
	localparam logic [31:0] ONE = 32'd1 << F;
	localparam logic [COLOR_W-1:0] CAP = (F > 15) ? 16'hFFFF : 16'(ONE);
	localparam logic [31:0] K08 = 32'(((64'd8 << F) + 64'd5) / 64'd10);
	localparam logic [31:0] K01 = 32'(((64'd1 << F) + 64'd5) / 64'd10);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SQ    = 10'b0000000010,
		S_ROOTL = 10'b0000000100,
		S_ROOTN = 10'b0000001000,
		S_LN    = 10'b0000010000,
		S_DIVD  = 10'b0000100000,
		S_DIVC  = 10'b0001000000,
		S_SPEC  = 10'b0010000000,
		S_CHAN  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [3:0] k_q;
	logic ph_q;
	logic [1:0] ch_q;
	logic [LDIR_W-1:0] lm_q [3];
	logic [NORM_W-1:0] nm_q [3];
	logic [2:0] neg_q;
	logic [LANE_W-1:0] dif_q [3];
	logic [LANE_W-1:0] inten_q [3];
	logic first_q;
	logic [L2_W-1:0] l2_q;
	logic [N2_W-1:0] n2_q;
	logic signed [DT_W-1:0] dt_q;
	logic [LEN_L_W-1:0] len_l_q;
	logic [LEN_N_W-1:0] len_n_q;
	logic [DEN_W-1:0] ln_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] c_q;
	logic [CW-1:0] cp_q;
	logic [CW-1:0] c8_q;
	logic [CW-1:0] spec_q;
	logic [31:0] id_q;
	logic [ACC_W-1:0] accw_q;
	logic [COLOR_W-1:0] acc_q [3];
	logic oval_q;
	logic [COLOR_W-1:0] ored_q, ogreen_q, oblue_q, odf_q;

	logic signed [LDIR_W-1:0] ldir [3];
	logic signed [NORM_W-1:0] ndir [3];
	logic [LDIR_W-1:0] lmag [3];
	logic [NORM_W-1:0] nmag [3];
	logic [2:0] lneg;
	logic [MUL_W-1:0] mul_a, mul_b;
	logic [2*MUL_W-1:0] mul_p;
	iter_req_t it_req;
	logic [X_W-1:0] it_a;
	logic [DEN_W-1:0] it_b;
	logic it_busy;
	logic [Q_W-1:0] it_res;
	logic d_ok, c_ok;
	logic [1:0] sq_idx;
	logic dif_le_one;
	logic [31:0] odif;
	logic [ACC_W-1:0] spec_t;
	logic [ACC_W-1:0] chan_sum;
	logic [COLOR_W-1:0] chan_new;
	logic [Q_W-1:0] c_full;
	logic accept;

	assign accept = light.valid && light.ready;
	assign light.ready = (state_q == S_IDLE);
	assign shade.valid = oval_q;
	assign shade.color_red = ored_q;
	assign shade.color_green = ogreen_q;
	assign shade.color_blue = oblue_q;
	assign shade.diffuse_factor = odf_q;

	always_comb begin
		ldir[0] = light.light_dir_x;
		ldir[1] = light.light_dir_y;
		ldir[2] = light.light_dir_z;
		ndir[0] = light.normal_x;
		ndir[1] = light.normal_y;
		ndir[2] = light.normal_z;
		for (int i = 0; i < 3; i++) begin
			lmag[i] = ldir[i][LDIR_W-1] ? LDIR_W'(-ldir[i]) : LDIR_W'(ldir[i]);
			nmag[i] = ndir[i][NORM_W-1] ? NORM_W'(-ndir[i]) : NORM_W'(ndir[i]);
			lneg[i] = ldir[i][LDIR_W-1] ^ ndir[i][NORM_W-1];
		end
	end

	assign d_ok = (dt_q > 0) && (len_l_q != '0);
	assign c_ok = d_ok && (len_n_q != '0);
	assign dif_le_one = 32'(dif_q[ch_q]) <= ONE;
	assign odif = dif_le_one ? ONE - 32'(dif_q[ch_q]) : 32'(dif_q[ch_q]) - ONE;
	assign spec_t = ACC_W'(mul_p >> F);
	assign c_full = (it_res > Q_W'(ONE)) ? Q_W'(ONE) : it_res;

	always_comb begin
		if (dif_le_one) begin
			chan_sum = accw_q + spec_t;
		end else begin
			chan_sum = (accw_q > spec_t) ? accw_q - spec_t : '0;
		end
		chan_new = (chan_sum > ACC_W'(CAP)) ? CAP : COLOR_W'(chan_sum);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sq_idx = 2'(k_q);
		if (k_q >= 4'd6) begin
			sq_idx = 2'(k_q - 4'd6);
		end else if (k_q >= 4'd3) begin
			sq_idx = 2'(k_q - 4'd3);
		end
		unique case (state_q)
			S_SQ: begin
				if (k_q < 4'd3) begin
					mul_a = 32'(lm_q[sq_idx]);
					mul_b = 32'(lm_q[sq_idx]);
				end else if (k_q < 4'd6) begin
					mul_a = 32'(nm_q[sq_idx]);
					mul_b = 32'(nm_q[sq_idx]);
				end else begin
					mul_a = 32'(lm_q[sq_idx]);
					mul_b = 32'(nm_q[sq_idx]);
				end
			end
			S_LN: begin
				mul_a = 32'(len_l_q);
				mul_b = 32'(len_n_q);
			end
			S_SPEC: begin
				unique case (k_q)
					4'd0: begin mul_a = 32'(c_q); mul_b = 32'(c_q); end
					4'd4: begin mul_a = 32'(cp_q); mul_b = 32'(c8_q); end
					4'd5: begin mul_a = 32'(cp_q); mul_b = 32'(c_q); end
					4'd6: begin mul_a = K08; mul_b = 32'(cp_q); end
					4'd7: begin mul_a = K01; mul_b = 32'(c_q); end
					default: begin mul_a = 32'(cp_q); mul_b = 32'(cp_q); end
				endcase
			end
			S_CHAN: begin
				unique case (k_q)
					4'd0: begin mul_a = 32'(inten_q[ch_q]); mul_b = 32'(dif_q[ch_q]); end
					4'd1: begin mul_a = 32'(d_q); mul_b = id_q; end
					default: begin mul_a = odif; mul_b = 32'(spec_q); end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		it_req.start = 1'b0;
		it_req.mode = IT_SQRT;
		it_a = '0;
		it_b = '0;
		unique case (state_q)
			S_ROOTL: begin
				it_req.start = !ph_q;
				it_a = X_W'(l2_q);
			end
			S_ROOTN: begin
				it_req.start = !ph_q;
				it_a = X_W'(n2_q);
			end
			S_DIVD: begin
				it_req.start = !ph_q && d_ok;
				it_req.mode = IT_DIV;
				it_a = X_W'(dt_q[DT_W-2:0]) << F;
				it_b = DEN_W'({len_l_q, 14'd0});
			end
			S_DIVC: begin
				it_req.start = !ph_q && c_ok;
				it_req.mode = IT_DIV;
				it_a = X_W'(dt_q[DT_W-2:0]) << F;
				it_b = ln_q;
			end
			default: begin
				it_req.start = 1'b0;
			end
		endcase
	end

	dss_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	dss_iter #(
		.COLOR_FRAC_BITS (COLOR_FRAC_BITS)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (it_req),
		.opnd_a (it_a),
		.opnd_b (it_b),
		.busy   (it_busy),
		.result (it_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			ph_q <= 1'b0;
			ch_q <= '0;
			for (int i = 0; i < 3; i++) begin
				lm_q[i] <= '0;
				nm_q[i] <= '0;
				dif_q[i] <= '0;
				inten_q[i] <= '0;
				acc_q[i] <= '0;
			end
			neg_q <= '0;
			first_q <= 1'b0;
			l2_q <= '0;
			n2_q <= '0;
			dt_q <= '0;
			len_l_q <= '0;
			len_n_q <= '0;
			ln_q <= '0;
			d_q <= '0;
			c_q <= '0;
			cp_q <= '0;
			c8_q <= '0;
			spec_q <= '0;
			id_q <= '0;
			accw_q <= '0;
			oval_q <= 1'b0;
			ored_q <= '0;
			ogreen_q <= '0;
			oblue_q <= '0;
			odf_q <= '0;
		end else begin
			if (shade.valid && shade.ready && state_q != S_OUT) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						for (int i = 0; i < 3; i++) begin
							lm_q[i] <= lmag[i];
							nm_q[i] <= nmag[i];
							dif_q[i] <= light.diffuse_rgb[LANE_W*i +: LANE_W];
							inten_q[i] <= light.intensity_rgb[LANE_W*i +: LANE_W];
						end
						neg_q <= lneg;
						first_q <= light.first_light;
						l2_q <= '0;
						n2_q <= '0;
						dt_q <= '0;
						k_q <= '0;
						ph_q <= 1'b0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (k_q < 4'd3) begin
							l2_q <= l2_q + mul_p[L2_W-1:0];
						end else if (k_q < 4'd6) begin
							n2_q <= n2_q + mul_p[N2_W-1:0];
						end else if (neg_q[sq_idx]) begin
							dt_q <= dt_q - $signed({1'b0, mul_p[DT_W-2:0]});
						end else begin
							dt_q <= dt_q + $signed({1'b0, mul_p[DT_W-2:0]});
						end
						if (k_q == 4'd8) begin
							k_q <= '0;
							state_q <= S_ROOTL;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_ROOTL: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (!it_busy) begin
						len_l_q <= it_res[LEN_L_W-1:0];
						ph_q <= 1'b0;
						state_q <= S_ROOTN;
					end
				end
				S_ROOTN: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (!it_busy) begin
						len_n_q <= it_res[LEN_N_W-1:0];
						ph_q <= 1'b0;
						state_q <= S_LN;
					end
				end
				S_LN: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						ln_q <= mul_p[DEN_W-1:0];
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (!ph_q) begin
						if (d_ok) begin
							ph_q <= 1'b1;
						end else begin
							d_q <= '0;
							state_q <= S_DIVC;
						end
					end else if (!it_busy) begin
						d_q <= it_res[DW-1:0];
						ph_q <= 1'b0;
						state_q <= S_DIVC;
					end
				end
				S_DIVC: begin
					if (!ph_q) begin
						if (c_ok) begin
							ph_q <= 1'b1;
						end else begin
							c_q <= '0;
							k_q <= '0;
							state_q <= S_SPEC;
						end
					end else if (!it_busy) begin
						c_q <= c_full[CW-1:0];
						ph_q <= 1'b0;
						k_q <= '0;
						state_q <= S_SPEC;
					end
				end
				S_SPEC: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						unique case (k_q)
							4'd6: spec_q <= CW'(mul_p >> F);
							4'd7: spec_q <= spec_q + CW'(mul_p >> F);
							default: cp_q <= CW'(mul_p >> F);
						endcase
						if (k_q == 4'd2) begin
							c8_q <= CW'(mul_p >> F);
						end
						if (k_q == 4'd7) begin
							k_q <= '0;
							ch_q <= '0;
							state_q <= S_CHAN;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_CHAN: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						unique case (k_q)
							4'd0: begin
								id_q <= mul_p[31:0];
								accw_q <= first_q ? '0 : ACC_W'(acc_q[ch_q]);
								k_q <= 4'd1;
							end
							4'd1: begin
								accw_q <= accw_q + ACC_W'(mul_p >> (2 * F));
								k_q <= 4'd2;
							end
							default: begin
								acc_q[ch_q] <= chan_new;
								k_q <= '0;
								if (ch_q == 2'd2) begin
									state_q <= S_OUT;
								end else begin
									ch_q <= ch_q + 1'b1;
								end
							end
						endcase
					end
				end
				S_OUT: begin
					if (!oval_q || shade.ready) begin
						oval_q <= 1'b1;
						ored_q <= acc_q[0];
						ogreen_q <= acc_q[1];
						oblue_q <= acc_q[2];
						odf_q <= (32'(d_q) > 32'(CAP)) ? CAP : 16'(d_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- src/dss_checker.sv -----
`timescale 1ns / 1ps
`include "diffuse_specular_shading_macros.svh"
module dss_checker import dss_pkg::*; #(
	parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               light_valid,
	input logic               light_ready,
	input logic               shade_valid,
	input logic               shade_ready,
	input logic [COLOR_W-1:0] color_red,
	input logic [COLOR_W-1:0] color_green,
	input logic [COLOR_W-1:0] color_blue,
	input logic [COLOR_W-1:0] diffuse_factor
);
	localparam logic [31:0] ONE = 32'd1 << COLOR_FRAC_BITS;
	localparam logic [COLOR_W-1:0] CAP = (COLOR_FRAC_BITS > 15) ? 16'hFFFF : 16'(ONE);

	`DSS_ASSERT_NEXT(a_busy_after_accept, light_valid && light_ready, !light_ready, "ready stayed high after a word was taken")
	`DSS_ASSERT_NEXT(a_result_held, shade_valid && !shade_ready, shade_valid && $stable(color_red) && $stable(diffuse_factor), "stalled result changed")
	`DSS_ASSERT_NOW(a_colour_capped, shade_valid, color_red <= CAP && color_green <= CAP && color_blue <= CAP, "colour above one")
	`DSS_ASSERT_NOW(a_factor_capped, shade_valid, diffuse_factor <= CAP, "diffuse factor above one")
endmodule

bind diffuse_specular_shading dss_checker #(
	.COLOR_FRAC_BITS (COLOR_FRAC_BITS)
) u_dss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.light_valid    (light.valid),
	.light_ready    (light.ready),
	.shade_valid    (shade.valid),
	.shade_ready    (shade.ready),
	.color_red      (shade.color_red),
	.color_green    (shade.color_green),
	.color_blue     (shade.color_blue),
	.diffuse_factor (shade.diffuse_factor)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import dss_pkg::*;

	localparam int F = COLOR_FRAC_BITS_DEF;
	localparam longint unsigned ONE = 64'd1 << F;
	localparam longint unsigned CAP = (ONE > 64'hFFFF) ? 64'hFFFF : ONE;
	localparam longint unsigned K08 = ((64'd8 << F) + 64'd5) / 64'd10;
	localparam longint unsigned K01 = ((64'd1 << F) + 64'd5) / 64'd10;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic                     first_light;
		logic signed [LDIR_W-1:0] ldir [3];
		logic signed [NORM_W-1:0] nrm [3];
		logic [RGB_W-1:0]         diffuse_rgb;
		logic [RGB_W-1:0]         intensity_rgb;
	} light_word_t;

	typedef struct {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] dfac;
	} shade_word_t;

	logic clk;
	logic arst_n;

	dss_in_if  light ();
	dss_out_if shade ();

	diffuse_specular_shading u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.light  (light),
		.shade  (shade)
	);

	light_word_t pending_lights [$];
	shade_word_t expected_shades [$];
	logic [COLOR_W-1:0] colour_acc [3];
	light_word_t on_bus;
	int errors;
	int send_gap;
	int recv_gap;
	int idle_cycles;
	bit burst_in;
	bit burst_out;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned scaled_div(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = num / den;
		r = num % den;
		for (int i = 0; i < F; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= den) begin
				r -= den;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned fmul(longint unsigned a, longint unsigned b);
		return (a * b) >> F;
	endfunction

	function automatic shade_word_t shade_light(light_word_t w);
		longint lv;
		longint nv;
		longint dt;
		longint unsigned l2, n2, len_l, len_n, d, c, c2, c4, c8, c16, p, spec;
		longint unsigned dif, inten, acc, sub;
		longint unsigned res [3];
		shade_word_t r;
		dt = 0;
		l2 = 0;
		n2 = 0;
		d = 0;
		c = 0;
		for (int i = 0; i < 3; i++) begin
			lv = w.ldir[i];
			nv = w.nrm[i];
			l2 += longint'(lv * lv);
			n2 += longint'(nv * nv);
			dt += lv * nv;
		end
		len_l = int_sqrt(l2);
		len_n = int_sqrt(n2);
		if (dt > 0 && len_l != 0) begin
			d = scaled_div(dt, len_l << 14);
			if (len_n != 0) begin
				c = scaled_div(dt, len_l * len_n);
				if (c > ONE)
					c = ONE;
			end
		end
		c2 = fmul(c, c);
		c4 = fmul(c2, c2);
		c8 = fmul(c4, c4);
		c16 = fmul(c8, c8);
		p = fmul(fmul(c16, c8), c);
		spec = fmul(K08, p) + fmul(K01, c);
		if (w.first_light)
			for (int i = 0; i < 3; i++)
				colour_acc[i] = '0;
		for (int i = 0; i < 3; i++) begin
			dif = (w.diffuse_rgb >> (16 * i)) & 64'hFFFF;
			inten = (w.intensity_rgb >> (16 * i)) & 64'hFFFF;
			acc = colour_acc[i];
			acc += (d * inten * dif) >> (2 * F);
			if (dif <= ONE) begin
				acc += fmul(ONE - dif, spec);
			end else begin
				sub = fmul(dif - ONE, spec);
				acc = (acc > sub) ? acc - sub : 0;
			end
			if (acc > CAP)
				acc = CAP;
			colour_acc[i] = acc[15:0];
			res[i] = acc;
		end
		r.red = res[0][15:0];
		r.green = res[1][15:0];
		r.blue = res[2][15:0];
		r.dfac = (d > CAP) ? CAP[15:0] : d[15:0];
		return r;
	endfunction

	function automatic int draw_gap(bit burst);
		if (burst)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light.valid <= 1'b0;
			light.first_light <= 1'b0;
			light.light_dir_x <= '0;
			light.light_dir_y <= '0;
			light.light_dir_z <= '0;
			light.normal_x <= '0;
			light.normal_y <= '0;
			light.normal_z <= '0;
			light.diffuse_rgb <= '0;
			light.intensity_rgb <= '0;
			send_gap <= 0;
			burst_in <= 1'b0;
		end else begin
			if (light.valid && light.ready)
				expected_shades.push_back(shade_light(on_bus));
			if (light.valid && !light.ready) begin
			end else if (send_gap != 0) begin
				light.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_lights.size() != 0) begin
				on_bus = pending_lights.pop_front();
				light.valid <= 1'b1;
				light.first_light <= on_bus.first_light;
				light.light_dir_x <= on_bus.ldir[0];
				light.light_dir_y <= on_bus.ldir[1];
				light.light_dir_z <= on_bus.ldir[2];
				light.normal_x <= on_bus.nrm[0];
				light.normal_y <= on_bus.nrm[1];
				light.normal_z <= on_bus.nrm[2];
				light.diffuse_rgb <= on_bus.diffuse_rgb;
				light.intensity_rgb <= on_bus.intensity_rgb;
				if ($urandom_range(0, 15) == 0)
					burst_in <= ~burst_in;
				send_gap <= draw_gap(burst_in);
			end else begin
				light.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		shade_word_t want;
		int gap;
		if (!arst_n) begin
			shade.ready <= 1'b0;
			recv_gap <= 0;
			burst_out <= 1'b0;
		end else begin
			if (shade.valid && shade.ready) begin
				if (expected_shades.size() == 0) begin
					$error("unexpected shade word");
					errors++;
				end else begin
					want = expected_shades.pop_front();
					if (shade.color_red !== want.red) begin
						$error("color_red: expected %0d, got %0d", want.red, shade.color_red);
						errors++;
					end
					if (shade.color_green !== want.green) begin
						$error("color_green: expected %0d, got %0d", want.green,
							shade.color_green);
						errors++;
					end
					if (shade.color_blue !== want.blue) begin
						$error("color_blue: expected %0d, got %0d", want.blue, shade.color_blue);
						errors++;
					end
					if (shade.diffuse_factor !== want.dfac) begin
						$error("diffuse_factor: expected %0d, got %0d", want.dfac,
							shade.diffuse_factor);
						errors++;
					end
				end
				if ($urandom_range(0, 15) == 0)
					burst_out <= ~burst_out;
				gap = draw_gap(burst_out);
				recv_gap <= gap;
				shade.ready <= (gap == 0);
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				shade.ready <= (recv_gap == 1);
			end else begin
				shade.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((light.valid && light.ready) || (shade.valid && shade.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic queue_light(logic fl, longint lx, longint ly, longint lz,
		longint nx, longint ny, longint nz, logic [RGB_W-1:0] dif, logic [RGB_W-1:0] inten);
		light_word_t w;
		w.first_light = fl;
		w.ldir[0] = LDIR_W'(lx);
		w.ldir[1] = LDIR_W'(ly);
		w.ldir[2] = LDIR_W'(lz);
		w.nrm[0] = NORM_W'(nx);
		w.nrm[1] = NORM_W'(ny);
		w.nrm[2] = NORM_W'(nz);
		w.diffuse_rgb = dif;
		w.intensity_rgb = inten;
		pending_lights.push_back(w);
	endtask

	function automatic logic [RGB_W-1:0] rand_rgb(bit wide);
		logic [RGB_W-1:0] v;
		for (int i = 0; i < 3; i++)
			v[16*i +: 16] = wide ? 16'($urandom) : 16'($urandom_range(0, 32768));
		return v;
	endfunction

	initial begin
		longint nx, ny, nz;
		int k;
		errors = 0;
		arst_n = 1'b0;
		for (int i = 0; i < 3; i++)
			colour_acc[i] = '0;

		queue_light(1, 0, 0, 0, 0, 0, 16384, 48'h4000_4000_4000, 48'h8000_8000_8000);
		queue_light(0, 0, 0, 1000, 0, 0, 0, 48'h4000_4000_4000, 48'h8000_8000_8000);
		queue_light(1, 0, 0, -1000, 0, 0, 16384, 48'h2000_2000_2000, 48'h8000_8000_8000);
		queue_light(1, 0, 0, 1000, 0, 0, 16384, 48'h0000_0000_0000, 48'h8000_8000_8000);
		queue_light(0, 0, 0, 1000, 0, 0, 16384, 48'h8000_8000_8000, 48'h8000_8000_8000);
		queue_light(0, 0, 0, 5000, 0, 0, 16384, 48'hFFFF_C000_9000, 48'hFFFF_FFFF_FFFF);
		queue_light(1, 8388607, 8388607, 8388607, 32767, 32767, 32767,
			48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		queue_light(0, -8388608, -8388608, -8388608, -32768, -32768, -32768,
			48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF);
		queue_light(1, -8388608, 0, 0, 32767, 0, 0, 48'h1234_5678_4000, 48'hFFFF_0000_8000);
		queue_light(0, 8388607, 0, 0, -32768, 0, 0, 48'h4000_4000_4000, 48'h8000_8000_8000);
		queue_light(1, 1, 0, 0, 32767, 0, 0, 48'h0000_8000_FFFF, 48'h8000_8000_8000);
		queue_light(0, 3, 4, 0, 9830, 13107, 0, 48'h2000_6000_0000, 48'hFFFF_8000_4000);
		queue_light(0, 0, 1, 0, 0, 1, 0, 48'h8000_8000_8000, 48'h8000_8000_8000);
		queue_light(1, 100, 100, 100, 0, 0, 0, 48'h0000_0000_0000, 48'h8000_8000_8000);
		for (int i = 0; i < 6; i++)
			queue_light(i == 0, 0, 0, 7000, 0, 0, 16384, 48'h0000_0000_0000, 48'h8000_8000_8000);

		for (int i = 0; i < 1050; i++) begin
			k = $urandom_range(0, 9);
			if (k < 4) begin
				nx = $signed(16'($urandom_range(0, 32767))) - 16384;
				ny = $signed(16'($urandom_range(0, 32767))) - 16384;
				nz = $signed(16'($urandom_range(0, 32767))) - 16384;
				k = $urandom_range(1, 250);
				queue_light($urandom_range(0, 3) == 0,
					nx * k + $signed(8'($urandom)), ny * k + $signed(8'($urandom)),
					nz * k + $signed(8'($urandom)), nx, ny, nz,
					rand_rgb($urandom_range(0, 4) == 0), rand_rgb($urandom_range(0, 1) == 1));
			end else if (k < 8) begin
				queue_light($urandom_range(0, 3) == 0,
					$signed(24'($urandom)) >>> $urandom_range(0, 20),
					$signed(24'($urandom)) >>> $urandom_range(0, 20),
					$signed(24'($urandom)) >>> $urandom_range(0, 20),
					$signed(16'($urandom_range(0, 32767))) - 16384,
					$signed(16'($urandom_range(0, 32767))) - 16384,
					$signed(16'($urandom_range(0, 32767))) - 16384,
					rand_rgb($urandom_range(0, 4) == 0), rand_rgb($urandom_range(0, 1) == 1));
			end else begin
				queue_light($urandom_range(0, 1) == 1,
					$signed(24'($urandom)), $signed(24'($urandom)), $signed(24'($urandom)),
					$signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
					rand_rgb(1), rand_rgb(1));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_lights.size() == 0 && !light.valid);
		wait (expected_shades.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_shades.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+src
src/dss_pkg.sv
src/dss_if.sv
src/dss_mul.sv
src/dss_iter.sv
src/diffuse_specular_shading.sv
src/dss_checker.sv
verif/testbench.sv
